FILE: hdl/tff_pkg.sv
// Package for the timed frame FIFO: sizes, operation codes and the frame
// and result types shared by the controller, the frame memory and the top level.
// No dependencies.
package tff_pkg;

  // Capacity, a power of two so that ring indexes wrap by truncation
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned CW       = $clog2(DEPTH + 1);
  localparam int unsigned COPY_MAX = 64;
  localparam int unsigned LW       = 7;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_COPY  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DATA,
    S_ISSUE
  } state_e;

  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
    logic [63:0]        clock;
  } frame_t;

  // One access to the frame memory: a write request and a read request
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    frame_t        wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic          ok;
    frame_t        frame;
    logic [CW-1:0] occupancy;
    logic          is_empty;
    logic          is_full;
    logic [CW-1:0] high_water;
    logic          last;
  } res_t;

endpackage

FILE: hdl/tff_mem.sv
// Frame memory of the timed frame FIFO: one write port, one read port,
// read data registered. Uses tff_pkg.
module tff_mem (
  input  logic              clk_i,
  input  tff_pkg::mem_req_t req_i,
  output tff_pkg::frame_t   rdata_o
);
  import tff_pkg::*;

  frame_t mem [DEPTH];
  frame_t rdata_q;

  // Write the pushed frame
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read one entry, hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tff_ctrl.sv
// Controller of the timed frame FIFO: ring pointers, high-water mark,
// copy-front sequencer and the output register. Uses tff_pkg; drives tff_mem.
module tff_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        op_i,
  input  tff_pkg::frame_t   push_frame_i,
  input  logic [tff_pkg::LW-1:0] copy_limit_i,
  output tff_pkg::mem_req_t mem_req_o,
  input  tff_pkg::frame_t   mem_rdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tff_pkg::res_t     out_o
);
  import tff_pkg::*;

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] peak_q, peak_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] rem_q, rem_d;
  logic          out_v_q, out_v_d;
  res_t          out_q, out_d;

  logic          accept;
  logic          out_free;
  logic          full, empty;
  logic [LW-1:0] lim_sat, copy_n;
  logic          do_push, do_pop, do_read, do_clear, direct, dir_ok;

  // Build a result with status taken from the given counters
  function automatic res_t make_res(logic ok, frame_t frame, logic [CW-1:0] fill,
                                    logic [CW-1:0] peak, logic last);
    res_t r;
    r.ok         = ok;
    r.frame      = frame;
    r.occupancy  = fill;
    r.is_empty   = (fill == '0);
    r.is_full    = (fill == CW'(DEPTH));
    r.high_water = peak;
    r.last       = last;
    return r;
  endfunction

  // The output register frees up when empty or being taken this cycle
  assign out_free   = !out_v_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (fill_q == CW'(DEPTH));
  assign empty = (fill_q == '0);

  // Frames a copy emits: limit saturated, then bounded by occupancy
  always_comb begin
    lim_sat = (copy_limit_i > LW'(COPY_MAX)) ? LW'(COPY_MAX) : copy_limit_i;
    copy_n  = (fill_q < CW'(lim_sat)) ? fill_q[LW-1:0] : lim_sat;
  end

  // Decode the accepted item
  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_read  = 1'b0;
    do_clear = 1'b0;
    if (accept) begin
      unique case (op_i)
        OP_PUSH:  do_push = !full;
        OP_POP: begin
          do_pop  = !empty;
          do_read = !empty;
        end
        OP_PEEK:  do_read = !empty;
        OP_COPY:  do_read = (copy_n != '0);
        OP_CLEAR: do_clear = 1'b1;
        default: ;
      endcase
    end
    direct = accept && !do_read;
    dir_ok = do_push || do_clear;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (do_read) state_d = S_DATA;
      S_DATA:  state_d = (rem_q == LW'(1)) ? S_IDLE : S_ISSUE;
      S_ISSUE: if (out_free) state_d = S_DATA;
      default: state_d = S_IDLE;
    endcase
  end

  // Pointers, memory requests and the output register
  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    peak_d  = peak_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    out_v_d = out_v_q && !out_ready_i;
    out_d   = out_q;

    mem_req_o.we    = do_push;
    mem_req_o.waddr = head_q + fill_q[AW-1:0];
    mem_req_o.wdata = push_frame_i;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (do_push) begin
          fill_d = fill_q + CW'(1);
          peak_d = (fill_d > peak_q) ? fill_d : peak_q;
        end
        if (do_clear) begin
          head_d = '0;
          fill_d = '0;
          peak_d = '0;
        end
        // Read the head entry; pop retires it right away
        if (do_read) begin
          mem_req_o.re = 1'b1;
          idx_d        = LW'(1);
          rem_d        = (op_i == OP_COPY) ? copy_n : LW'(1);
        end
        if (do_pop) begin
          head_d = head_q + AW'(1);
          fill_d = fill_q - CW'(1);
        end
        if (direct) begin
          out_v_d = 1'b1;
          out_d   = make_res(dir_ok, '0, fill_d, peak_d, 1'b1);
        end
      end
      S_DATA: begin
        out_v_d = 1'b1;
        out_d   = make_res(1'b1, mem_rdata_i, fill_q, peak_q, rem_q == LW'(1));
        rem_d   = rem_q - LW'(1);
      end
      S_ISSUE: begin
        // Fetch the next frame of the copy once the output slot frees up
        if (out_free) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = head_q + AW'(idx_q);
          idx_d           = idx_q + LW'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      peak_q  <= '0;
      idx_q   <= '0;
      rem_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      peak_q  <= peak_d;
      idx_q   <= idx_d;
      rem_q   <= rem_d;
      out_v_q <= out_v_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

FILE: hdl/timed_frame_fifo_core.sv
// Timed frame FIFO: a 1024-entry ring of timestamped stereo frames held in one
// synchronous memory, with push, pop, peek, copy-front and clear operations.
// Push, clear and every refused operation finish without a memory read, so
// such items can follow each other back to back while the output is taken. A
// successful pop or peek reads the frame memory, which returns the read data in
// the cycle after the address. A copy-front reads each frame from the memory
// and then places it in the single output register, holding the input until
// its last frame is read; backpressure on the output lengthens it. No clearing
// pass follows reset; the block takes items as soon as reset is released.
// Depends on tff_pkg, tff_ctrl and tff_mem.
module timed_frame_fifo_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // push_clock[63:0], push_left[79:64], push_right[95:80], copy_limit[102:96], zero
  input  logic [103:0] s_axis_tdata_i,
  // op[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // frame_clock[63:0], frame_left[79:64], frame_right[95:80], occupancy[106:96],
  // is_empty[107], is_full[108], high_water[119:109]
  output logic [119:0] m_axis_tdata_o,
  // ok[0]
  output logic         m_axis_tuser_o,
  output logic         m_axis_tlast_o
);
  import tff_pkg::*;

  frame_t   push_frame;
  mem_req_t mem_req;
  frame_t   mem_rdata;
  res_t     res;

  // Unpack the input item
  assign push_frame.clock = s_axis_tdata_i[63:0];
  assign push_frame.left  = s_axis_tdata_i[79:64];
  assign push_frame.right = s_axis_tdata_i[95:80];

  tff_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .op_i         (s_axis_tuser_i),
    .push_frame_i (push_frame),
    .copy_limit_i (s_axis_tdata_i[102:96]),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (res)
  );

  tff_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Pack the result item
  assign m_axis_tdata_o = {res.high_water, res.is_full, res.is_empty, res.occupancy,
                           res.frame.right, res.frame.left, res.frame.clock};
  assign m_axis_tuser_o = res.ok;
  assign m_axis_tlast_o = res.last;

  // Occupancy never exceeds capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res.occupancy <= CW'(DEPTH)))
    else $error("occupancy above capacity");

  // High-water mark covers the current occupancy
  a_peak_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res.high_water >= res.occupancy))
    else $error("high-water mark below occupancy");

  // Empty flag agrees with occupancy
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res.is_empty == (res.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  // A refused result never carries a frame timestamp and is always last
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res.ok) |-> (res.frame.clock == '0 && res.last))
    else $error("refused result carries a frame or is not last");

endmodule
